/* hw/rtl/rwbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_pkg: shared constants and types of the rgb white balance classifier
// widths, calibration depth, register codes and divider lane control
// ----------------------------------------------------------------------------
package rwbc_pkg;

   localparam int CAL_SAMPLES = 8;

   localparam int RAW_W      = 16;
   localparam int NORM_W     = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int SUM_W      = RAW_W + ((CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 0);
   localparam int CNT_W      = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
   localparam int SCALED_W   = RAW_W + NORM_W;
   localparam int DVD_W      = (SCALED_W > SUM_W) ? SCALED_W : SUM_W;
   localparam int DSR_W      = RAW_W;
   localparam int STEP_W     = $clog2(DVD_W);

   localparam logic [NORM_W-1:0] FULL_SCALE = 8'd255;

   localparam logic [CSR_DATA_W-1:0] DIFF_THRESHOLD_RST = 8'd50;
   localparam logic [CSR_DATA_W-1:0] WHITE_LEVEL_RST    = 8'd200;
   localparam logic [CSR_DATA_W-1:0] BLACK_LEVEL_RST    = 8'd30;

   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_LEVEL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_LEVEL    = 2'd2;

   localparam logic OP_MEASURE   = 1'b0;
   localparam logic OP_CALIBRATE = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/rwbc_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_req_if: request channel
// valid/ready handshake carrying one measure or calibration request
// ----------------------------------------------------------------------------
interface rwbc_req_if;
   import rwbc_pkg::*;

   logic             valid;
   logic             ready;
   logic             operation;
   logic [RAW_W-1:0] raw_red;
   logic [RAW_W-1:0] raw_green;
   logic [RAW_W-1:0] raw_blue;

   modport source (output valid, output operation, output raw_red, output raw_green,
                   output raw_blue, input ready);
   modport sink   (input valid, input operation, input raw_red, input raw_green,
                   input raw_blue, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rwbc_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_rsp_if: response channel
// valid/ready handshake carrying normalized channels and color flags
// ----------------------------------------------------------------------------
interface rwbc_rsp_if;
   import rwbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [NORM_W-1:0] norm_red;
   logic [NORM_W-1:0] norm_green;
   logic [NORM_W-1:0] norm_blue;
   logic              is_calibrated;
   logic              flag_red;
   logic              flag_green;
   logic              flag_blue;
   logic              flag_white;
   logic              flag_black;

   modport source (output valid, output norm_red, output norm_green, output norm_blue,
                   output is_calibrated, output flag_red, output flag_green,
                   output flag_blue, output flag_white, output flag_black, input ready);
   modport sink   (input valid, input norm_red, input norm_green, input norm_blue,
                   input is_calibrated, input flag_red, input flag_green,
                   input flag_blue, input flag_white, input flag_black, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rwbc_serial_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_serial_div: bit-serial restoring divider lane
// one quotient bit per step; quotient shifts into the dividend register
// ----------------------------------------------------------------------------
module rwbc_serial_div (
   input  logic                         clock,
   input  rwbc_pkg::div_ctrl_type       ctrl,
   input  logic [rwbc_pkg::DVD_W-1:0]   dividend,
   input  logic [rwbc_pkg::DSR_W-1:0]   divisor,
   output logic [rwbc_pkg::DVD_W-1:0]   quotient
);
   import rwbc_pkg::*;

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   shifted;
   logic [DSR_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      ge      = (shifted >= {1'b0, dsr_ff});
      diff    = shifted - {1'b0, dsr_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (ctrl.load) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (ctrl.step) begin
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = dvd_ff;

endmodule
`default_nettype wire

/* hw/rtl/rgb_white_balance_classifier_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_white_balance_classifier_top: white balance normalizer and classifier
// averages white calibration samples into per-channel references and
// normalizes measurements as raw*255/ref with dominance and level flags
//
//   channel   direction   contents
//   req_chan  in          operation, raw_red, raw_green, raw_blue
//   rsp_chan  out         norm_red/green/blue, is_calibrated, five flags
//   csr_*     in          diff_threshold, white_level, black_level writes
//
// calibrated measure: accept, 24 divider steps, then the result state
// last calibration sample runs the same 24 steps to average; other
// calibration samples only add into the sums and uncalibrated measures skip the steps
// three bit-serial divider lanes, one per channel, run together; the dividend width sets the step count
// reset is synchronous; no clearing pass is needed
// a held response stalls only the next measure's final cycle
// ----------------------------------------------------------------------------
module rgb_white_balance_classifier_top (
   input  logic                              clock,
   input  logic                              reset,
   rwbc_req_if.sink                          req_chan,
   rwbc_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [rwbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rwbc_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import rwbc_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(CAL_SAMPLES - 1);

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_cnt_ff, step_cnt_in;
   logic              mode_cal_ff, mode_cal_in;

   logic [CSR_DATA_W-1:0] diff_thr_ff, diff_thr_in;
   logic [CSR_DATA_W-1:0] white_lvl_ff, white_lvl_in;
   logic [CSR_DATA_W-1:0] black_lvl_ff, black_lvl_in;

   logic [DSR_W-1:0] ref_r_ff, ref_r_in, ref_g_ff, ref_g_in, ref_b_ff, ref_b_in;
   logic [SUM_W-1:0] sum_r_ff, sum_r_in, sum_g_ff, sum_g_in, sum_b_ff, sum_b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cal_ff, cal_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NORM_W-1:0] norm_r_ff, norm_r_in, norm_g_ff, norm_g_in, norm_b_ff, norm_b_in;
   logic              is_cal_ff, is_cal_in;
   logic [4:0]        flags_ff, flags_in;

   div_ctrl_type     div_ctrl;
   logic [DVD_W-1:0] dvd_r, dvd_g, dvd_b;
   logic [DSR_W-1:0] dsr_r, dsr_g, dsr_b;
   logic [DVD_W-1:0] quo_r, quo_g, quo_b;
   logic [SUM_W-1:0] new_sum_r, new_sum_g, new_sum_b;
   logic [NORM_W-1:0] nr, ng, nb;
   logic             req_fire;

   function automatic logic [NORM_W-1:0] sat_norm(input logic [DVD_W-1:0] q);
      return (q > DVD_W'(FULL_SCALE)) ? FULL_SCALE : q[NORM_W-1:0];
   endfunction

   function automatic logic [DSR_W-1:0] make_ref(input logic [DVD_W-1:0] q);
      return (q[DSR_W-1:0] == '0) ? DSR_W'(1) : q[DSR_W-1:0];
   endfunction

   function automatic logic dominant(input logic [NORM_W-1:0] a, input logic [NORM_W-1:0] b,
                                     input logic [NORM_W-1:0] c,
                                     input logic [CSR_DATA_W-1:0] t);
      return (a > b) && (a > c) && ((a - b) > t) && ((a - c) > t);
   endfunction

   function automatic logic [DVD_W-1:0] scale(input logic [RAW_W-1:0] raw);
      return DVD_W'({raw, {NORM_W{1'b0}}}) - DVD_W'(raw);
   endfunction

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign new_sum_r = sum_r_ff + SUM_W'(req_chan.raw_red);
   assign new_sum_g = sum_g_ff + SUM_W'(req_chan.raw_green);
   assign new_sum_b = sum_b_ff + SUM_W'(req_chan.raw_blue);

   assign nr = sat_norm(quo_r);
   assign ng = sat_norm(quo_g);
   assign nb = sat_norm(quo_b);

   // divider lane operands
   always_comb begin
      if (req_chan.operation == OP_CALIBRATE) begin
         dvd_r = DVD_W'(new_sum_r);
         dvd_g = DVD_W'(new_sum_g);
         dvd_b = DVD_W'(new_sum_b);
         dsr_r = DSR_W'(CAL_SAMPLES);
         dsr_g = DSR_W'(CAL_SAMPLES);
         dsr_b = DSR_W'(CAL_SAMPLES);
      end else begin
         dvd_r = cal_ff ? scale(req_chan.raw_red)   : '0;
         dvd_g = cal_ff ? scale(req_chan.raw_green) : '0;
         dvd_b = cal_ff ? scale(req_chan.raw_blue)  : '0;
         dsr_r = ref_r_ff;
         dsr_g = ref_g_ff;
         dsr_b = ref_b_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      mode_cal_in  = mode_cal_ff;
      diff_thr_in  = diff_thr_ff;
      white_lvl_in = white_lvl_ff;
      black_lvl_in = black_lvl_ff;
      ref_r_in     = ref_r_ff;
      ref_g_in     = ref_g_ff;
      ref_b_in     = ref_b_ff;
      sum_r_in     = sum_r_ff;
      sum_g_in     = sum_g_ff;
      sum_b_in     = sum_b_ff;
      cnt_in       = cnt_ff;
      cal_in       = cal_ff;
      rsp_valid_in = rsp_valid_ff;
      norm_r_in    = norm_r_ff;
      norm_g_in    = norm_g_ff;
      norm_b_in    = norm_b_ff;
      is_cal_in    = is_cal_ff;
      flags_in     = flags_ff;
      div_ctrl     = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIFF_THRESHOLD: diff_thr_in  = csr_wr_data;
            CSR_WHITE_LEVEL:    white_lvl_in = csr_wr_data;
            CSR_BLACK_LEVEL:    black_lvl_in = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               step_cnt_in = '0;
               mode_cal_in = (req_chan.operation == OP_CALIBRATE);
               if (req_chan.operation == OP_CALIBRATE) begin
                  if (cnt_ff == LAST_CNT) begin
                     div_ctrl.load = 1'b1;
                     sum_r_in      = '0;
                     sum_g_in      = '0;
                     sum_b_in      = '0;
                     cnt_in        = '0;
                     state_in      = ST_DIV;
                  end else begin
                     sum_r_in = new_sum_r;
                     sum_g_in = new_sum_g;
                     sum_b_in = new_sum_b;
                     cnt_in   = cnt_ff + 1'b1;
                  end
               end else begin
                  div_ctrl.load = 1'b1;
                  state_in      = cal_ff ? ST_DIV : ST_DONE;
               end
            end
         end
         ST_DIV: begin
            div_ctrl.step = 1'b1;
            step_cnt_in   = step_cnt_ff + 1'b1;
            if (step_cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (mode_cal_ff) begin
               ref_r_in = make_ref(quo_r);
               ref_g_in = make_ref(quo_g);
               ref_b_in = make_ref(quo_b);
               cal_in   = 1'b1;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               norm_r_in    = nr;
               norm_g_in    = ng;
               norm_b_in    = nb;
               is_cal_in    = cal_ff;
               flags_in[0]  = dominant(nr, ng, nb, diff_thr_ff);
               flags_in[1]  = dominant(ng, nr, nb, diff_thr_ff);
               flags_in[2]  = dominant(nb, nr, ng, diff_thr_ff);
               flags_in[3]  = (nr > white_lvl_ff) && (ng > white_lvl_ff) &&
                              (nb > white_lvl_ff);
               flags_in[4]  = (nr < black_lvl_ff) && (ng < black_lvl_ff) &&
                              (nb < black_lvl_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         mode_cal_ff  <= 1'b0;
         diff_thr_ff  <= DIFF_THRESHOLD_RST;
         white_lvl_ff <= WHITE_LEVEL_RST;
         black_lvl_ff <= BLACK_LEVEL_RST;
         ref_r_ff     <= DSR_W'(1);
         ref_g_ff     <= DSR_W'(1);
         ref_b_ff     <= DSR_W'(1);
         sum_r_ff     <= '0;
         sum_g_ff     <= '0;
         sum_b_ff     <= '0;
         cnt_ff       <= '0;
         cal_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         mode_cal_ff  <= mode_cal_in;
         diff_thr_ff  <= diff_thr_in;
         white_lvl_ff <= white_lvl_in;
         black_lvl_ff <= black_lvl_in;
         ref_r_ff     <= ref_r_in;
         ref_g_ff     <= ref_g_in;
         ref_b_ff     <= ref_b_in;
         sum_r_ff     <= sum_r_in;
         sum_g_ff     <= sum_g_in;
         sum_b_ff     <= sum_b_in;
         cnt_ff       <= cnt_in;
         cal_ff       <= cal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      norm_r_ff <= norm_r_in;
      norm_g_ff <= norm_g_in;
      norm_b_ff <= norm_b_in;
      is_cal_ff <= is_cal_in;
      flags_ff  <= flags_in;
   end

   rwbc_serial_div u_div_red (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (dvd_r),
      .divisor  (dsr_r),
      .quotient (quo_r)
   );

   rwbc_serial_div u_div_green (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (dvd_g),
      .divisor  (dsr_g),
      .quotient (quo_g)
   );

   rwbc_serial_div u_div_blue (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (dvd_b),
      .divisor  (dsr_b),
      .quotient (quo_b)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.norm_red      = norm_r_ff;
   assign rsp_chan.norm_green    = norm_g_ff;
   assign rsp_chan.norm_blue     = norm_b_ff;
   assign rsp_chan.is_calibrated = is_cal_ff;
   assign rsp_chan.flag_red      = flags_ff[0];
   assign rsp_chan.flag_green    = flags_ff[1];
   assign rsp_chan.flag_blue     = flags_ff[2];
   assign rsp_chan.flag_white    = flags_ff[3];
   assign rsp_chan.flag_black    = flags_ff[4];

   // calibration is sticky
   a_cal_sticky: assert property (@(posedge clock) disable iff (reset)
      cal_ff |=> cal_ff)
      else $error("calibrated flag dropped");

   // white references never reach zero
   a_ref_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ref_r_ff != '0) && (ref_g_ff != '0) && (ref_b_ff != '0))
      else $error("white reference is zero");

   // uncalibrated responses carry zero channels
   a_uncal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !is_cal_ff) |->
      ((norm_r_ff == '0) && (norm_g_ff == '0) && (norm_b_ff == '0)))
      else $error("uncalibrated response not zero");

   // divider step counter advances every step cycle
   a_step_adv: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && (step_cnt_ff != LAST_STEP)) |=>
      ((state_ff == ST_DIV) && (step_cnt_ff == STEP_W'($past(step_cnt_ff) + 1'b1))))
      else $error("divider step sequence broken");

endmodule
`default_nettype wire

/* test/rgb_white_balance_classifier_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_white_balance_classifier_top_tb: self-checking bench for the classifier
// drives measure and calibration requests through the request channel,
// predicts normalized channels and color flags, and checks every response
// under random idling, a long response hold-off and register changes
// ----------------------------------------------------------------------------
module rgb_white_balance_classifier_top_tb;
   import rwbc_pkg::*;

   typedef struct packed {
      logic [NORM_W-1:0] norm_red;
      logic [NORM_W-1:0] norm_green;
      logic [NORM_W-1:0] norm_blue;
      logic              is_calibrated;
      logic              flag_red;
      logic              flag_green;
      logic              flag_blue;
      logic              flag_white;
      logic              flag_black;
   } color_result_type;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS    = 760;
   localparam int END_WAIT_LIMIT  = 20000;
   localparam int TIMEOUT_NS      = 6000000;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   rwbc_req_if req_chan ();
   rwbc_rsp_if rsp_chan ();

   rgb_white_balance_classifier_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predicted block state
   logic [CSR_DATA_W-1:0] thr_diff  = DIFF_THRESHOLD_RST;
   logic [CSR_DATA_W-1:0] lvl_white = WHITE_LEVEL_RST;
   logic [CSR_DATA_W-1:0] lvl_black = BLACK_LEVEL_RST;
   logic [RAW_W-1:0] white_red   = RAW_W'(1);
   logic [RAW_W-1:0] white_green = RAW_W'(1);
   logic [RAW_W-1:0] white_blue  = RAW_W'(1);
   logic [SUM_W-1:0] accum_red   = '0;
   logic [SUM_W-1:0] accum_green = '0;
   logic [SUM_W-1:0] accum_blue  = '0;
   int               cal_count   = 0;
   logic             have_white  = 1'b0;

   color_result_type expected_colors[$];
   int            mismatches   = 0;
   logic          steady_run   = 1'b0;
   logic          rsp_hold_req = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [NORM_W-1:0] scale_channel(input logic [RAW_W-1:0] raw,
                                                      input logic [RAW_W-1:0] white);
      logic [SCALED_W-1:0] prod;
      logic [SCALED_W-1:0] quot;
      prod = SCALED_W'(raw) * SCALED_W'(FULL_SCALE);
      quot = prod / SCALED_W'(white);
      if (quot > SCALED_W'(FULL_SCALE)) return FULL_SCALE;
      return quot[NORM_W-1:0];
   endfunction

   function automatic logic dominates(input logic [NORM_W-1:0] a, b, c);
      return (a > b) && (a > c) && ((a - b) > thr_diff) && ((a - c) > thr_diff);
   endfunction

   function automatic logic [RAW_W-1:0] average_of(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] quot;
      quot = sum / SUM_W'(CAL_SAMPLES);
      return (quot[RAW_W-1:0] == '0) ? RAW_W'(1) : quot[RAW_W-1:0];
   endfunction

   // raw count that lands near k/255 of the current white reference
   function automatic logic [RAW_W-1:0] level_of(input logic [RAW_W-1:0] white,
                                                 input int unsigned k);
      longint unsigned v;
      v = longint'(white) * k / 255;
      return (v > 65535) ? '1 : RAW_W'(v);
   endfunction

   task automatic classify_request(input logic op, input logic [RAW_W-1:0] r, g, b);
      color_result_type c;
      if (op == OP_CALIBRATE) begin
         accum_red   += SUM_W'(r);
         accum_green += SUM_W'(g);
         accum_blue  += SUM_W'(b);
         cal_count++;
         if (cal_count >= CAL_SAMPLES) begin
            white_red   = average_of(accum_red);
            white_green = average_of(accum_green);
            white_blue  = average_of(accum_blue);
            accum_red   = '0;
            accum_green = '0;
            accum_blue  = '0;
            cal_count   = 0;
            have_white  = 1'b1;
         end
      end else begin
         c = '0;
         if (have_white) begin
            c.norm_red   = scale_channel(r, white_red);
            c.norm_green = scale_channel(g, white_green);
            c.norm_blue  = scale_channel(b, white_blue);
         end
         c.is_calibrated = have_white;
         c.flag_red   = dominates(c.norm_red, c.norm_green, c.norm_blue);
         c.flag_green = dominates(c.norm_green, c.norm_red, c.norm_blue);
         c.flag_blue  = dominates(c.norm_blue, c.norm_red, c.norm_green);
         c.flag_white = (c.norm_red > lvl_white) && (c.norm_green > lvl_white) &&
                        (c.norm_blue > lvl_white);
         c.flag_black = (c.norm_red < lvl_black) && (c.norm_green < lvl_black) &&
                        (c.norm_blue < lvl_black);
         expected_colors.push_back(c);
      end
   endtask

   task automatic send_request(input logic op, input logic [RAW_W-1:0] r, g, b);
      if (!steady_run && $urandom_range(99) < 27) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.raw_red   <= r;
      req_chan.raw_green <= g;
      req_chan.raw_blue  <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      classify_request(op, r, g, b);
   endtask

   task automatic wait_for_idle(input int extra);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_DIFF_THRESHOLD: thr_diff  = data;
         CSR_WHITE_LEVEL:    lvl_white = data;
         CSR_BLACK_LEVEL:    lvl_black = data;
         default: ;
      endcase
   endtask

   task automatic send_random_measure();
      int mode;
      int unsigned kr, kg, kb;
      mode = $urandom_range(99);
      if (mode < 20) begin
         send_request(OP_MEASURE, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
         return;
      end
      if (mode < 30) begin
         kr = $urandom_range(190, 320);
         kg = $urandom_range(190, 320);
         kb = $urandom_range(190, 320);
      end else if (mode < 40) begin
         kr = $urandom_range(0, 45);
         kg = $urandom_range(0, 45);
         kb = $urandom_range(0, 45);
      end else begin
         kr = $urandom_range(0, 300);
         kg = $urandom_range(0, 300);
         kb = $urandom_range(0, 300);
      end
      send_request(OP_MEASURE, level_of(white_red, kr), level_of(white_green, kg),
                   level_of(white_blue, kb));
   endtask

   task automatic send_calibration_set(input int count);
      int style;
      int i;
      logic [RAW_W-1:0] base_r, base_g, base_b;
      style  = $urandom_range(9);
      base_r = RAW_W'($urandom_range(16, 60000));
      base_g = RAW_W'($urandom_range(16, 60000));
      base_b = RAW_W'($urandom_range(16, 60000));
      for (i = 0; i < count; i++) begin
         if (style == 0)
            send_request(OP_CALIBRATE, RAW_W'($urandom_range(0, 15)),
                         RAW_W'($urandom_range(0, 15)), RAW_W'($urandom_range(0, 15)));
         else if (style < 3)
            send_request(OP_CALIBRATE, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
         else
            send_request(OP_CALIBRATE, base_r + RAW_W'($urandom_range(0, 4095)),
                         base_g + RAW_W'($urandom_range(0, 4095)),
                         base_b + RAW_W'($urandom_range(0, 4095)));
      end
   endtask

   task automatic randomize_config();
      case ($urandom_range(9))
         0:       write_csr(CSR_DIFF_THRESHOLD, '0);
         1:       write_csr(CSR_DIFF_THRESHOLD, '1);
         default: write_csr(CSR_DIFF_THRESHOLD, CSR_DATA_W'($urandom_range(0, 120)));
      endcase
      case ($urandom_range(9))
         0:       write_csr(CSR_WHITE_LEVEL, '0);
         1:       write_csr(CSR_WHITE_LEVEL, '1);
         default: write_csr(CSR_WHITE_LEVEL, CSR_DATA_W'($urandom_range(150, 254)));
      endcase
      case ($urandom_range(9))
         0:       write_csr(CSR_BLACK_LEVEL, '0);
         1:       write_csr(CSR_BLACK_LEVEL, '1);
         default: write_csr(CSR_BLACK_LEVEL, CSR_DATA_W'($urandom_range(1, 60)));
      endcase
      if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
   endtask

   task automatic test_uncalibrated();
      send_request(OP_MEASURE, '0, '0, '0);
      send_request(OP_MEASURE, '1, '1, '1);
      send_request(OP_MEASURE, '1, '0, '0);
      wait_for_idle(DRAIN_CYCLES);
      write_csr(CSR_BLACK_LEVEL, '0);
      send_request(OP_MEASURE, 16'd1234, 16'd0, 16'd65535);
      wait_for_idle(DRAIN_CYCLES);
      write_csr(CSR_BLACK_LEVEL, BLACK_LEVEL_RST);
   endtask

   task automatic test_zero_reference();
      repeat (CAL_SAMPLES) send_request(OP_CALIBRATE, 16'd1, 16'd0, 16'd15);
      send_request(OP_MEASURE, '0, '0, '0);
      send_request(OP_MEASURE, 16'd1, 16'd0, 16'd3);
   endtask

   task automatic test_recalibration();
      repeat (CAL_SAMPLES / 2) send_request(OP_CALIBRATE, 16'd40000, 16'd30000, 16'd20000);
      // old references still apply mid-set
      send_request(OP_MEASURE, 16'd1, 16'd0, 16'd3);
      repeat (CAL_SAMPLES - CAL_SAMPLES / 2)
         send_request(OP_CALIBRATE, 16'd40000, 16'd30000, 16'd20000);
      send_request(OP_MEASURE, '1, '1, '1);
      send_request(OP_MEASURE, 16'd40000, 16'd10000, 16'd5000);
   endtask

   task automatic test_config_extremes();
      wait_for_idle(DRAIN_CYCLES);
      write_csr(CSR_DIFF_THRESHOLD, '0);
      write_csr(CSR_WHITE_LEVEL, '0);
      write_csr(CSR_BLACK_LEVEL, '1);
      send_request(OP_MEASURE, 16'd40000, 16'd15000, 16'd5000);
      send_request(OP_MEASURE, 16'd20000, 16'd15000, 16'd10000);
      wait_for_idle(DRAIN_CYCLES);
      write_csr(CSR_DIFF_THRESHOLD, '1);
      write_csr(CSR_WHITE_LEVEL, '1);
      write_csr(CSR_BLACK_LEVEL, '0);
      write_csr(CSR_UNUSED, '0);
      send_request(OP_MEASURE, '1, '0, '0);
      wait_for_idle(DRAIN_CYCLES);
      write_csr(CSR_DIFF_THRESHOLD, DIFF_THRESHOLD_RST);
      write_csr(CSR_WHITE_LEVEL, WHITE_LEVEL_RST);
      write_csr(CSR_BLACK_LEVEL, BLACK_LEVEL_RST);
   endtask

   task automatic test_response_backpressure();
      rsp_hold_req = 1'b1;
      repeat (16) send_random_measure();
   endtask

   task automatic test_sender_pause();
      repeat (6) send_random_measure();
      wait_for_idle(0);
      repeat (6) send_random_measure();
   endtask

   task automatic test_random_traffic();
      int items;
      int choice;
      int n;
      items = 0;
      while (items < RANDOM_ITEMS) begin
         steady_run = (items >= 300) && (items < 420);
         choice = $urandom_range(99);
         if (choice < 4) begin
            wait_for_idle(DRAIN_CYCLES);
            randomize_config();
         end else if (choice < 16) begin
            send_calibration_set(CAL_SAMPLES);
            items += CAL_SAMPLES;
         end else if (choice < 20) begin
            n = $urandom_range(1, CAL_SAMPLES - 1);
            send_calibration_set(n);
            items += n;
         end else begin
            send_random_measure();
            items++;
         end
      end
      steady_run = 1'b0;
   endtask

   // response side: random ready, always ready in the steady run, plus one long hold-off on request
   initial begin : rsp_sink
      int held;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            for (held = 0; held < RSP_HOLD_CYCLES; held++) @(posedge clock);
         end else if (steady_run) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= 27);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      color_result_type seen;
      color_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.norm_red, rsp_chan.norm_green, rsp_chan.norm_blue,
                  rsp_chan.is_calibrated, rsp_chan.flag_red, rsp_chan.flag_green,
                  rsp_chan.flag_blue, rsp_chan.flag_white, rsp_chan.flag_black};
         if (expected_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response rgb=%0d/%0d/%0d", $realtime,
                        seen.norm_red, seen.norm_green, seen.norm_blue);
         end else begin
            want = expected_colors.pop_front();
            if (seen.norm_red !== want.norm_red || seen.norm_green !== want.norm_green ||
                seen.norm_blue !== want.norm_blue ||
                seen.is_calibrated !== want.is_calibrated ||
                seen.flag_red !== want.flag_red || seen.flag_green !== want.flag_green ||
                seen.flag_blue !== want.flag_blue || seen.flag_white !== want.flag_white ||
                seen.flag_black !== want.flag_black) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch exp rgb=%0d/%0d/%0d cal=%b rgbwk=%b%b%b%b%b",
                           $realtime, want.norm_red, want.norm_green, want.norm_blue,
                           want.is_calibrated, want.flag_red, want.flag_green,
                           want.flag_blue, want.flag_white, want.flag_black,
                           " got rgb=%0d/%0d/%0d cal=%b rgbwk=%b%b%b%b%b",
                           seen.norm_red, seen.norm_green, seen.norm_blue,
                           seen.is_calibrated, seen.flag_red, seen.flag_green,
                           seen.flag_blue, seen.flag_white, seen.flag_black);
            end
         end
      end
   end

   initial begin : main
      int waited;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_MEASURE;
      req_chan.raw_red   <= '0;
      req_chan.raw_green <= '0;
      req_chan.raw_blue  <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= '0;
      csr_wr_data        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_uncalibrated();
      test_zero_reference();
      test_recalibration();
      test_config_extremes();
      test_response_backpressure();
      test_sender_pause();
      test_random_traffic();

      req_chan.valid <= 1'b0;
      waited = 0;
      while (expected_colors.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_colors.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* rgb_white_balance_classifier_top.f */
hw/rtl/rwbc_pkg.sv
hw/rtl/rwbc_req_if.sv
hw/rtl/rwbc_rsp_if.sv
hw/rtl/rwbc_serial_div.sv
hw/rtl/rgb_white_balance_classifier_top.sv
test/rgb_white_balance_classifier_top_tb.sv
